@@ hw/rtl/csa_pkg.sv @@
// Shared constants, types and helper functions of the set-associative cache hit/miss core.
package csa_pkg;

   // Address and payload widths.
   localparam int ADDR_BITS      = 32;
   localparam int COUNT_W        = 32;
   localparam int MAX_BLOCKS_DEF = 1024;

   // The tag store is organized as rows of LANES entries read side by side.
   localparam int LANES  = 8;
   localparam int LANE_W = 3;

   // Configuration register widths and reset values.
   localparam int POLICY_W      = 1;
   localparam int WAYS_LOG2_W   = 4;
   localparam int BLOCKS_LOG2_W = 4;
   localparam int OFFSET_W      = 3;

   localparam logic [POLICY_W-1:0]      POLICY_RST      = 1'b0;
   localparam logic [WAYS_LOG2_W-1:0]   WAYS_LOG2_RST   = 4'd0;
   localparam logic [BLOCKS_LOG2_W-1:0] BLOCKS_LOG2_RST = 4'd4;
   localparam logic [OFFSET_W-1:0]      OFFSET_RST      = 3'd5;

   // Configuration port.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] REG_POLICY_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WAYS_LOG2   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BLOCKS_LOG2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_BITS = 2'd3;

   // Replacement policies.
   localparam logic [POLICY_W-1:0] POLICY_FIFO   = 1'b0;
   localparam logic [POLICY_W-1:0] POLICY_RANDOM = 1'b1;

   // Pseudo-random victim generator.
   localparam int               LFSR_W    = 16;
   localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

   // Controller states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_WAIT,
      ST_DECIDE,
      ST_OUT
   } state_type;

   // Effective cache geometry after clamping the configuration.
   typedef struct packed {
      logic [POLICY_W-1:0]    policy_mode;
      logic [WAYS_LOG2_W-1:0] ways_log2;
      logic [WAYS_LOG2_W-1:0] set_bits;
      logic [OFFSET_W-1:0]    offset_bits;
   } geom_type;

   // One tag store entry.
   typedef struct packed {
      logic                 valid;
      logic [ADDR_BITS-1:0] tag;
   } entry_type;

   // Write request into one row of the tag store.
   typedef struct packed {
      logic [LANES-1:0] lane_en;
      entry_type        entry;
   } tag_wr_type;

   // One step of the Fibonacci LFSR with taps 16, 14, 13 and 11.
   function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
      logic fb;
      fb = v[0] ^ v[2] ^ v[3] ^ v[5];
      return {fb, v[LFSR_W-1:1]};
   endfunction

endpackage

@@ hw/rtl/csa_if.sv @@
// Handshake channel interfaces for requests, responses and configuration writes.

// Request channel: one byte address per transfer.
interface csa_req_if;
   logic                          valid;
   logic                          ready;
   logic [csa_pkg::ADDR_BITS-1:0] address;

   modport source (output valid, output address, input ready);
   modport sink   (input valid, input address, output ready);
endinterface

// Response channel: hit flag and running counts.
interface csa_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        hit;
   logic [csa_pkg::COUNT_W-1:0] hit_count;
   logic [csa_pkg::COUNT_W-1:0] miss_count;

   modport source (output valid, output hit, output hit_count, output miss_count, input ready);
   modport sink   (input valid, input hit, input hit_count, input miss_count, output ready);
endinterface

// Configuration write channel.
interface csa_csr_if;
   logic                           valid;
   logic                           ready;
   logic [csa_pkg::CSR_IDX_W-1:0]  index;
   logic [csa_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/csa_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module csa_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port with registered read data.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/csa_cfg.sv @@
// Configuration registers and the clamped cache geometry derived from them.
module csa_cfg #(
   parameter int CapLog2 = 10
) (
   input  logic              clock,
   input  logic              reset,
   csa_csr_if.sink           csr_chan,
   output csa_pkg::geom_type geom
);

   logic [csa_pkg::POLICY_W-1:0]      policy_ff, policy_in;
   logic [csa_pkg::WAYS_LOG2_W-1:0]   ways_ff, ways_in;
   logic [csa_pkg::BLOCKS_LOG2_W-1:0] blocks_ff, blocks_in;
   logic [csa_pkg::OFFSET_W-1:0]      offset_ff, offset_in;
   logic [csa_pkg::BLOCKS_LOG2_W-1:0] blocks_eff;
   logic [csa_pkg::WAYS_LOG2_W-1:0]   ways_eff;

   // Writes are always taken.
   assign csr_chan.ready = 1'b1;

   // Register write decode; indexes beyond the list leave everything unchanged.
   always_comb begin
      policy_in = policy_ff;
      ways_in   = ways_ff;
      blocks_in = blocks_ff;
      offset_in = offset_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            csa_pkg::REG_POLICY_MODE: policy_in = csr_chan.data[csa_pkg::POLICY_W-1:0];
            csa_pkg::REG_WAYS_LOG2:   ways_in   = csr_chan.data[csa_pkg::WAYS_LOG2_W-1:0];
            csa_pkg::REG_BLOCKS_LOG2: blocks_in = csr_chan.data[csa_pkg::BLOCKS_LOG2_W-1:0];
            csa_pkg::REG_OFFSET_BITS: offset_in = csr_chan.data[csa_pkg::OFFSET_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= csa_pkg::POLICY_RST;
         ways_ff   <= csa_pkg::WAYS_LOG2_RST;
         blocks_ff <= csa_pkg::BLOCKS_LOG2_RST;
         offset_ff <= csa_pkg::OFFSET_RST;
      end else begin
         policy_ff <= policy_in;
         ways_ff   <= ways_in;
         blocks_ff <= blocks_in;
         offset_ff <= offset_in;
      end
   end

   // Clamp the block count to the store size and the associativity to the block count.
   always_comb begin
      blocks_eff = (blocks_ff > csa_pkg::BLOCKS_LOG2_W'(CapLog2)) ?
                   csa_pkg::BLOCKS_LOG2_W'(CapLog2) : blocks_ff;
      ways_eff   = (ways_ff > blocks_eff) ? blocks_eff : ways_ff;
      geom.policy_mode = policy_ff;
      geom.ways_log2   = ways_eff;
      geom.set_bits    = blocks_eff - ways_eff;
      geom.offset_bits = offset_ff;
   end

endmodule

@@ hw/rtl/csa_tag_array.sv @@
// Tag store built from one RAM per lane, with a tag compare across a whole row.
module csa_tag_array #(
   parameter int RowCount = 128
) (
   input  logic                               clock,
   input  logic [$clog2(RowCount)-1:0]        rd_row,
   input  logic [$clog2(RowCount)-1:0]        wr_row,
   input  csa_pkg::tag_wr_type                wr_req,
   input  logic [csa_pkg::ADDR_BITS-1:0]      cmp_tag,
   input  logic [csa_pkg::LANES-1:0]          lane_sel,
   output logic                               row_hit
);

   csa_pkg::entry_type         rd_entry [csa_pkg::LANES];
   logic [csa_pkg::LANES-1:0]  lane_match;

   // One RAM per lane so that a single entry can be written without touching its row.
   for (genvar l = 0; l < csa_pkg::LANES; l++) begin : g_lane
      csa_ram #(
         .Width ($bits(csa_pkg::entry_type)),
         .Depth (RowCount)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_req.lane_en[l]),
         .wr_addr (wr_row),
         .wr_data (wr_req.entry),
         .rd_addr (rd_row),
         .rd_data (rd_entry[l])
      );
   end

   // Compare every selected lane of the row read in the previous cycle.
   always_comb begin
      for (int l = 0; l < csa_pkg::LANES; l++) begin
         lane_match[l] = lane_sel[l] && rd_entry[l].valid && (rd_entry[l].tag == cmp_tag);
      end
      row_hit = |lane_match;
   end

endmodule

@@ hw/rtl/set_assoc_cache_hit_miss_sim_core.sv @@
// Top level of the set-associative cache hit/miss core with FIFO or random replacement.
//
// Usage: each transfer on req_chan carries one 32-bit byte address. For every accepted
// address the core returns one transfer on rsp_chan with the hit flag and the saturating
// running hit and miss counts, including that access. csr_chan writes the four
// configuration registers (policy, log2 ways, log2 blocks, offset bits); it is always
// ready and must only be used while no access is in flight.
// The tag store lives in lane RAMs read one row of eight entries per cycle, so the scan
// of a set reads max(1, ways / 8) rows. From acceptance until the next address can be
// taken, an access passes through the scan, a state for the last compare, one to update
// the set, one to load the response register (which waits until that register is free),
// and the idle state in which the next address is taken.
// After reset the core clears the tag store and all MaxBlocks (1024 by default) FIFO
// pointers, with req_chan.ready low; configuration writes are still taken.
// A stalled response stays in the output register; the core accepts the next address
// meanwhile and holds that result until the register is free.
module set_assoc_cache_hit_miss_sim_core #(
   parameter int MaxBlocks = csa_pkg::MAX_BLOCKS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   csa_req_if.sink   req_chan,
   csa_rsp_if.source rsp_chan,
   csa_csr_if.sink   csr_chan
);

   localparam int EntryW   = $clog2(MaxBlocks);
   localparam int RowCount = MaxBlocks / csa_pkg::LANES;
   localparam int RowW     = $clog2(RowCount);
   localparam int LaneW    = csa_pkg::LANE_W;
   localparam int AddrW    = csa_pkg::ADDR_BITS;
   localparam int CountW   = csa_pkg::COUNT_W;
   localparam int WayW     = csa_pkg::WAYS_LOG2_W;

   csa_pkg::geom_type  geom;
   csa_pkg::state_type state_ff, state_in;

   logic [EntryW-1:0]          clr_cnt_ff, clr_cnt_in;
   logic [EntryW-1:0]          set_ff, set_in;
   logic [EntryW-1:0]          base_ff, base_in;
   logic [AddrW-1:0]           tag_ff, tag_in;
   logic [RowW-1:0]            row_cnt_ff, row_cnt_in;
   logic                       hit_ff, hit_in;
   logic                       rd_pend_ff, rd_pend_in;
   logic [csa_pkg::LFSR_W-1:0] lfsr_ff, lfsr_in;
   logic [CountW-1:0]          hits_ff, hits_in;
   logic [CountW-1:0]          misses_ff, misses_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_hit_ff, rsp_hit_in;
   logic [CountW-1:0]          rsp_hits_ff, rsp_hits_in;
   logic [CountW-1:0]          rsp_misses_ff, rsp_misses_in;

   logic                       req_xfer;
   logic                       rsp_free;
   logic [AddrW-1:0]           set_full;
   logic [4:0]                 tag_shift;
   logic [RowW-1:0]            row_last;
   logic [RowW-1:0]            rd_row;
   logic [csa_pkg::LANES-1:0]  lane_sel;
   logic                       row_hit;
   logic [EntryW-1:0]          ways_mask;
   logic [csa_pkg::LFSR_W-1:0] lfsr_adv;
   logic [EntryW-1:0]          victim;
   logic [EntryW-1:0]          victim_entry;
   logic [EntryW-1:0]          fifo_rd_data;
   logic                       fifo_wr_en;
   logic [EntryW-1:0]          fifo_wr_addr;
   logic [EntryW-1:0]          fifo_wr_data;
   logic [RowW-1:0]            tag_wr_row;
   csa_pkg::tag_wr_type        tag_wr;

   // Configuration registers.
   csa_cfg #(
      .CapLog2 (EntryW)
   ) u_cfg (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .geom     (geom)
   );

   // Tag store with valid flags.
   csa_tag_array #(
      .RowCount (RowCount)
   ) u_tags (
      .clock    (clock),
      .rd_row   (rd_row),
      .wr_row   (tag_wr_row),
      .wr_req   (tag_wr),
      .cmp_tag  (tag_ff),
      .lane_sel (lane_sel),
      .row_hit  (row_hit)
   );

   // Per-set FIFO replacement pointers.
   csa_ram #(
      .Width (EntryW),
      .Depth (MaxBlocks)
   ) u_fifo_ptr (
      .clock   (clock),
      .wr_en   (fifo_wr_en),
      .wr_addr (fifo_wr_addr),
      .wr_data (fifo_wr_data),
      .rd_addr (set_ff),
      .rd_data (fifo_rd_data)
   );

   // Channel handshakes.
   assign req_chan.ready = (state_ff == csa_pkg::ST_IDLE);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.hit        = rsp_hit_ff;
   assign rsp_chan.hit_count  = rsp_hits_ff;
   assign rsp_chan.miss_count = rsp_misses_ff;

   // Address split into set index, tag and first entry of the set.
   always_comb begin
      set_full  = (req_chan.address >> geom.offset_bits) &
                  ~({AddrW{1'b1}} << geom.set_bits);
      set_in    = set_full[EntryW-1:0];
      tag_shift = {2'b00, geom.offset_bits} + {1'b0, geom.set_bits};
      tag_in    = req_chan.address >> tag_shift;
      base_in   = set_in << geom.ways_log2;
   end

   // Rows spanned by one set and the lanes of the row that belong to it.
   always_comb begin
      if (geom.ways_log2 >= WayW'(LaneW)) begin
         row_last = ~({RowW{1'b1}} << (geom.ways_log2 - WayW'(LaneW)));
      end else begin
         row_last = '0;
      end
      rd_row = base_ff[EntryW-1:LaneW] + row_cnt_ff;
      for (int l = 0; l < csa_pkg::LANES; l++) begin
         lane_sel[l] = (geom.ways_log2 >= WayW'(LaneW)) ||
                       (((LaneW'(l) ^ base_ff[LaneW-1:0]) >> geom.ways_log2) == '0);
      end
   end

   // Victim selection for a miss.
   always_comb begin
      ways_mask    = ~({EntryW{1'b1}} << geom.ways_log2);
      lfsr_adv     = csa_pkg::lfsr_next(lfsr_ff);
      if (geom.policy_mode == csa_pkg::POLICY_RANDOM) begin
         victim = lfsr_adv[EntryW-1:0] & ways_mask;
      end else begin
         victim = fifo_rd_data & ways_mask;
      end
      victim_entry = base_ff | victim;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         csa_pkg::ST_CLEAR: begin
            if (clr_cnt_ff == EntryW'(MaxBlocks - 1)) begin
               state_in = csa_pkg::ST_IDLE;
            end
         end
         csa_pkg::ST_IDLE: begin
            if (req_xfer) begin
               state_in = csa_pkg::ST_SCAN;
            end
         end
         csa_pkg::ST_SCAN: begin
            if (row_cnt_ff == row_last) begin
               state_in = csa_pkg::ST_WAIT;
            end
         end
         csa_pkg::ST_WAIT:   state_in = csa_pkg::ST_DECIDE;
         csa_pkg::ST_DECIDE: state_in = csa_pkg::ST_OUT;
         csa_pkg::ST_OUT: begin
            if (rsp_free) begin
               state_in = csa_pkg::ST_IDLE;
            end
         end
         default: state_in = csa_pkg::ST_CLEAR;
      endcase
   end

   // Datapath and memory control for each state.
   always_comb begin
      clr_cnt_in    = clr_cnt_ff;
      row_cnt_in    = row_cnt_ff;
      hit_in        = hit_ff;
      rd_pend_in    = (state_ff == csa_pkg::ST_SCAN);
      lfsr_in       = lfsr_ff;
      hits_in       = hits_ff;
      misses_in     = misses_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_hits_in   = rsp_hits_ff;
      rsp_misses_in = rsp_misses_ff;
      fifo_wr_en    = 1'b0;
      fifo_wr_addr  = set_ff;
      fifo_wr_data  = (victim + EntryW'(1)) & ways_mask;
      tag_wr_row    = victim_entry[EntryW-1:LaneW];
      tag_wr.lane_en     = '0;
      tag_wr.entry.valid = 1'b1;
      tag_wr.entry.tag   = tag_ff;

      // Accumulate the compare of the row read in the previous cycle.
      if (rd_pend_ff && row_hit) begin
         hit_in = 1'b1;
      end

      // The response register drains independently of the controller.
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         csa_pkg::ST_CLEAR: begin
            clr_cnt_in         = clr_cnt_ff + EntryW'(1);
            fifo_wr_en         = 1'b1;
            fifo_wr_addr       = clr_cnt_ff;
            fifo_wr_data       = '0;
            tag_wr_row         = clr_cnt_ff[RowW-1:0];
            tag_wr.lane_en     = '1;
            tag_wr.entry.valid = 1'b0;
            tag_wr.entry.tag   = '0;
         end
         csa_pkg::ST_IDLE: begin
            row_cnt_in = '0;
            if (req_xfer) begin
               hit_in = 1'b0;
            end
         end
         csa_pkg::ST_SCAN: begin
            row_cnt_in = row_cnt_ff + RowW'(1);
         end
         csa_pkg::ST_WAIT: ;
         csa_pkg::ST_DECIDE: begin
            if (hit_ff) begin
               if (hits_ff != '1) begin
                  hits_in = hits_ff + CountW'(1);
               end
            end else begin
               if (misses_ff != '1) begin
                  misses_in = misses_ff + CountW'(1);
               end
               if (geom.policy_mode == csa_pkg::POLICY_RANDOM) begin
                  lfsr_in = lfsr_adv;
               end else begin
                  fifo_wr_en = 1'b1;
               end
               tag_wr.lane_en = csa_pkg::LANES'(1) << victim_entry[LaneW-1:0];
            end
         end
         csa_pkg::ST_OUT: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_hit_in    = hit_ff;
               rsp_hits_in   = hits_ff;
               rsp_misses_in = misses_ff;
            end
         end
         default: ;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= csa_pkg::ST_CLEAR;
         clr_cnt_ff   <= '0;
         row_cnt_ff   <= '0;
         rd_pend_ff   <= 1'b0;
         lfsr_ff      <= csa_pkg::LFSR_SEED;
         hits_ff      <= '0;
         misses_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         row_cnt_ff   <= row_cnt_in;
         rd_pend_ff   <= rd_pend_in;
         lfsr_ff      <= lfsr_in;
         hits_ff      <= hits_in;
         misses_ff    <= misses_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         set_ff  <= set_in;
         tag_ff  <= tag_in;
         base_ff <= base_in;
      end
      hit_ff        <= hit_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_hits_ff   <= rsp_hits_in;
      rsp_misses_ff <= rsp_misses_in;
   end

   // The running counts never move backward.
   assert property (@(posedge clock) disable iff (reset)
      (hits_ff >= $past(hits_ff)) && (misses_ff >= $past(misses_ff)))
      else $error("running count decreased");

   // An access is counted either as a hit or as a miss, never both.
   assert property (@(posedge clock) disable iff (reset)
      (hits_ff != $past(hits_ff)) |-> (misses_ff == $past(misses_ff)))
      else $error("hit and miss counted together");

   // The tag store is written only by the clearing sweep or by a miss.
   assert property (@(posedge clock) disable iff (reset)
      (tag_wr.lane_en != '0) |->
      ((state_ff == csa_pkg::ST_CLEAR) || ((state_ff == csa_pkg::ST_DECIDE) && !hit_ff)))
      else $error("unexpected tag store write");

   // A new response is loaded only when the controller finishes an access.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == csa_pkg::ST_OUT))
      else $error("response loaded outside the output state");

   // The LFSR never falls into the all-zero lockup state.
   assert property (@(posedge clock) disable iff (reset)
      lfsr_ff != '0)
      else $error("LFSR reached zero");

endmodule
